@@ rtl/fll_pkg.sv @@
// Package for the forest LCA / link-cut block: field types, codes, beat structs.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none
package fll_pkg;

  localparam int NODES_DEF = 256;
  localparam int KEY_W     = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LINK   = 2'd1,
    OP_CUT    = 2'd2,
    OP_LCA    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // link kind held beside each parent pointer
  localparam logic [1:0] KIND_ROOT   = 2'd0;
  localparam logic [1:0] KIND_LINKED = 2'd1;
  localparam logic [1:0] KIND_CUT    = 2'd2;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key_a;
    logic signed [KEY_W-1:0] key_b;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic signed [KEY_W-1:0] ancestor_key;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/fll_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on fll_pkg for default sizes only.
`default_nettype none
module fll_ram #(
  parameter int WIDTH = fll_pkg::KEY_W,
  parameter int DEPTH = fll_pkg::NODES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/fll_core.sv @@
// Sequencer, shared key comparator and slot walker of the forest LCA block.
// Depends on fll_pkg and fll_ram (key, link and mark stores).
`default_nettype none
module fll_core #(
  parameter int NODES = fll_pkg::NODES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire fll_pkg::req_t item,
  output logic              idle,
  output logic              res_valid,
  input  wire logic         res_ready,
  output fll_pkg::rsp_t     res
);

  localparam int SLOT_W = $clog2(NODES);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int LINK_W = SLOT_W + 2;
  localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(NODES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SRCH_A, S_SRCH_B, S_APPLY,
    S_MARK_RD, S_MARK_CHK, S_BW_RD, S_BW_CHK,
    S_KEY_RD, S_KEY_WAIT, S_CLR_RD, S_CLR_CHK, S_DONE
  } state_t;

  state_t                      state;
  fll_pkg::op_t                op;
  logic [fll_pkg::KEY_W-1:0]   key_a;
  logic [fll_pkg::KEY_W-1:0]   key_b;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            scan;
  logic [SLOT_W-1:0]           prev;
  logic                        pend;
  logic [SLOT_W-1:0]           sa;
  logic [SLOT_W-1:0]           sb;
  logic [SLOT_W-1:0]           cur;
  logic [SLOT_W-1:0]           steps;
  logic                        do_clr;
  fll_pkg::status_t            status;
  logic [fll_pkg::KEY_W-1:0]   anc;

  // store ports
  logic                        key_we;
  logic [SLOT_W-1:0]           key_waddr;
  logic [fll_pkg::KEY_W-1:0]   key_wdata;
  logic [SLOT_W-1:0]           key_raddr;
  logic [fll_pkg::KEY_W-1:0]   key_rd;
  logic                        link_we;
  logic [SLOT_W-1:0]           link_waddr;
  logic [LINK_W-1:0]           link_wdata;
  logic [LINK_W-1:0]           link_rd;
  logic                        mark_we;
  logic [SLOT_W-1:0]           mark_waddr;
  logic                        mark_wdata;
  logic                        mark_rd;

  logic [fll_pkg::KEY_W-1:0]   target;
  logic                        hit;
  logic                        scan_end;
  logic [1:0]                  link_kind;
  logic [SLOT_W-1:0]           link_par;
  logic                        step_ok;
  logic                        last;

  fll_ram #(.WIDTH(fll_pkg::KEY_W), .DEPTH(NODES)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rd)
  );

  fll_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(cur), .rdata(link_rd)
  );

  fll_ram #(.WIDTH(1), .DEPTH(NODES)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(cur), .rdata(mark_rd)
  );

  // shared comparator and walk step
  assign target    = (state == S_SRCH_B) ? key_b : key_a;
  assign hit       = pend && (key_rd == target);
  assign scan_end  = (scan >= count);
  assign link_kind = link_rd[LINK_W-1 -: 2];
  assign link_par  = link_rd[SLOT_W-1:0];
  assign step_ok   = (link_kind == fll_pkg::KIND_LINKED) && ({1'b0, link_par} < count);
  assign last      = (steps == LAST_STEP);

  always_comb begin
    key_we     = 1'b0;
    key_waddr  = count[SLOT_W-1:0];
    key_wdata  = key_a;
    key_raddr  = cur;
    link_we    = 1'b0;
    link_waddr = count[SLOT_W-1:0];
    link_wdata = {fll_pkg::KIND_ROOT, count[SLOT_W-1:0]};
    mark_we    = 1'b0;
    mark_waddr = cur;
    mark_wdata = 1'b0;
    unique case (state)
      S_SRCH_A, S_SRCH_B: begin
        key_raddr = scan[SLOT_W-1:0];
      end
      S_APPLY: begin
        unique case (op)
          fll_pkg::OP_INSERT: begin
            key_we     = 1'b1;
            link_we    = 1'b1;
            mark_we    = 1'b1;
            mark_waddr = count[SLOT_W-1:0];
          end
          fll_pkg::OP_LINK: begin
            link_we    = 1'b1;
            link_waddr = sb;
            link_wdata = {fll_pkg::KIND_LINKED, sa};
          end
          fll_pkg::OP_CUT: begin
            link_we    = 1'b1;
            link_waddr = sa;
            link_wdata = {fll_pkg::KIND_CUT, {SLOT_W{1'b0}}};
          end
          fll_pkg::OP_LCA: begin
          end
        endcase
      end
      S_MARK_RD: begin
        mark_we    = 1'b1;
        mark_wdata = 1'b1;
      end
      S_CLR_RD: begin
        mark_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op    <= item.op;
            key_a <= item.key_a;
            key_b <= item.key_b;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          anc    <= '0;
          do_clr <= 1'b0;
          scan   <= '0;
          pend   <= 1'b0;
          priority if (op == fll_pkg::OP_INSERT) begin
            if (count == FULL_CNT) begin
              status <= fll_pkg::ST_FULL;
              state  <= S_DONE;
            end else begin
              status <= fll_pkg::ST_OK;
              state  <= S_APPLY;
            end
          end else if (count == '0) begin
            status <= fll_pkg::ST_EMPTY;
            state  <= S_DONE;
          end else begin
            status <= fll_pkg::ST_OK;
            state  <= S_SRCH_A;
          end
        end
        S_SRCH_A, S_SRCH_B: begin
          prev <= scan[SLOT_W-1:0];
          priority if (hit) begin
            scan <= '0;
            pend <= 1'b0;
            if (state == S_SRCH_A) begin
              sa    <= prev;
              state <= (op == fll_pkg::OP_CUT) ? S_APPLY : S_SRCH_B;
            end else begin
              sb    <= prev;
              cur   <= sa;
              steps <= '0;
              priority if (op == fll_pkg::OP_LINK) begin
                state <= S_APPLY;
              end else if (prev == sa) begin
                state <= S_KEY_RD;
              end else begin
                state <= S_MARK_RD;
              end
            end
          end else if (scan_end) begin
            status <= fll_pkg::ST_NOT_FOUND;
            pend   <= 1'b0;
            state  <= S_DONE;
          end else begin
            scan <= scan + 1'b1;
            pend <= (scan < count);
          end
        end
        S_APPLY: begin
          if (op == fll_pkg::OP_INSERT) begin
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end
        S_MARK_RD: begin
          state <= S_MARK_CHK;
        end
        S_MARK_CHK: begin
          if (!step_ok || last) begin
            cur   <= sb;
            steps <= '0;
            state <= S_BW_RD;
          end else begin
            cur   <= link_par;
            steps <= steps + 1'b1;
            state <= S_MARK_RD;
          end
        end
        S_BW_RD: begin
          state <= S_BW_CHK;
        end
        S_BW_CHK: begin
          priority if (mark_rd) begin
            do_clr <= 1'b1;
            state  <= S_KEY_RD;
          end else if (!step_ok || last) begin
            status <= fll_pkg::ST_NOT_FOUND;
            cur    <= sa;
            steps  <= '0;
            state  <= S_CLR_RD;
          end else begin
            cur   <= link_par;
            steps <= steps + 1'b1;
            state <= S_BW_RD;
          end
        end
        S_KEY_RD: begin
          state <= S_KEY_WAIT;
        end
        S_KEY_WAIT: begin
          anc <= key_rd;
          if (do_clr) begin
            cur   <= sa;
            steps <= '0;
            state <= S_CLR_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_CLR_RD: begin
          state <= S_CLR_CHK;
        end
        S_CLR_CHK: begin
          if (!step_ok || last) begin
            state <= S_DONE;
          end else begin
            cur   <= link_par;
            steps <= steps + 1'b1;
            state <= S_CLR_RD;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign idle             = (state == S_IDLE);
  assign res_valid        = (state == S_DONE);
  assign res.status       = status;
  assign res.ancestor_key = anc;

endmodule
`default_nettype wire

@@ rtl/forest_lca_link_cut.sv @@
// Top level of the forest LCA / link-cut block: handshakes and result register.
// Depends on fll_pkg and fll_core.
//
//   channel | beat type       | handshake              | direction
//   --------+-----------------+------------------------+----------
//   req     | fll_pkg::req_t  | req_valid / req_ready  | in
//   rsp     | fll_pkg::rsp_t  | rsp_valid / rsp_ready  | out
//
// Beats are handled one at a time by the sequencer, which has one key comparator
// and one read per store per cycle.
// Reset (rst, synchronous) empties the table; the stores themselves are not swept.
// A stalled rsp holds in the output register while the next req is taken;
// a second result then waits in the sequencer until the register frees.
`default_nettype none
module forest_lca_link_cut #(
  parameter int NODES = fll_pkg::NODES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire fll_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output fll_pkg::rsp_t      rsp
);

  logic          core_idle;
  logic          res_valid;
  logic          res_ready;
  fll_pkg::rsp_t res;

  // take a new beat whenever the sequencer is idle
  assign req_ready = core_idle;

  fll_core #(.NODES(NODES)) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (req_valid && req_ready),
    .item      (req),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: load when empty or being drained this cycle
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fll_checker.sv @@
// Port-level checker for forest_lca_link_cut, bound to the top level below.
// Depends on fll_pkg.
`default_nettype none
module fll_sva (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire fll_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire fll_pkg::rsp_t rsp
);

  // nothing to deliver straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp_valid high after reset");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled rsp beat changed");

  // one beat at a time: busy after each accepted request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req_ready high straight after accepting a beat");

  // a failed operation carries a zero key
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != fll_pkg::ST_OK) |-> rsp.ancestor_key == '0)
    else $error("ancestor_key non-zero on a failed operation");

endmodule

bind forest_lca_link_cut fll_sva u_fll_sva (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire

@@ sim/fll_checker.sv @@
`timescale 1ns / 100ps
// Checker for forest_lca_link_cut: watches both beat channels, predicts each result.
// Depends on fll_pkg for the beat structs, the op and status codes and the link kinds.
module fll_checker
  import fll_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);

  logic [KEY_W-1:0] key_of    [NODES];
  int unsigned      parent_of [NODES];
  logic [1:0]       kind_of   [NODES];
  int unsigned      filled;
  rsp_t             forest_results_q[$];
  int               mismatches;

  // Lowest filled slot holding the key wins.
  function automatic bit find_slot(input logic [KEY_W-1:0] k, output int unsigned s);
    s = 0;
    for (int unsigned i = 0; i < filled; i++) begin
      if (key_of[i] == k) begin
        s = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit climb(input int unsigned s, output int unsigned up);
    up = 0;
    if (kind_of[s] != KIND_LINKED || parent_of[s] >= filled) return 1'b0;
    up = parent_of[s];
    return 1'b1;
  endfunction

  function automatic rsp_t forest_apply(input req_t r);
    rsp_t        res;
    int unsigned sa;
    int unsigned sb;
    int unsigned cur;
    int unsigned up;
    bit          on_path [NODES];
    bit          fa;
    bit          fb;
    bit          hit;
    res.status       = ST_OK;
    res.ancestor_key = '0;
    foreach (on_path[i]) on_path[i] = 1'b0;
    if (r.op == OP_INSERT) begin
      if (filled >= NODES) begin
        res.status = ST_FULL;
      end else begin
        key_of[filled]    = r.key_a;
        parent_of[filled] = filled;
        kind_of[filled]   = KIND_ROOT;
        filled++;
      end
    end else if (filled == 0) begin
      res.status = ST_EMPTY;
    end else if (r.op == OP_LINK) begin
      fa = find_slot(r.key_a, sa);
      fb = find_slot(r.key_b, sb);
      if (!(fa && fb)) begin
        res.status = ST_NOT_FOUND;
      end else begin
        parent_of[sb] = sa;
        kind_of[sb]   = KIND_LINKED;
      end
    end else if (r.op == OP_CUT) begin
      if (!find_slot(r.key_a, sa)) res.status = ST_NOT_FOUND;
      else kind_of[sa] = KIND_CUT;
    end else begin
      fa = find_slot(r.key_a, sa);
      fb = find_slot(r.key_b, sb);
      if (!(fa && fb)) begin
        res.status = ST_NOT_FOUND;
      end else if (sa == sb) begin
        res.ancestor_key = key_of[sa];
      end else begin
        // mark A and its ancestors, bounded so a cycle ends
        cur = sa;
        for (int n = 0; n < NODES; n++) begin
          on_path[cur] = 1'b1;
          if (!climb(cur, up)) break;
          cur = up;
        end
        hit = 1'b0;
        cur = sb;
        for (int n = 0; n < NODES; n++) begin
          if (on_path[cur]) begin
            hit = 1'b1;
            break;
          end
          if (!climb(cur, up)) break;
          cur = up;
        end
        if (hit) res.ancestor_key = key_of[cur];
        else res.status = ST_NOT_FOUND;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      filled = 0;
      forest_results_q.delete();
    end else begin
      if (req_valid && req_ready) forest_results_q.push_back(forest_apply(req));
      if (rsp_valid && rsp_ready) begin
        if (forest_results_q.size() == 0) begin
          mismatches++;
          $error("result beat with no request outstanding: status %0d key %0d",
                 rsp.status, rsp.ancestor_key);
        end else begin
          want = forest_results_q.pop_front();
          if (rsp.status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
          end
          if (rsp.ancestor_key !== want.ancestor_key) begin
            mismatches++;
            $error("ancestor_key: expected %0d, actual %0d",
                   want.ancestor_key, rsp.ancestor_key);
          end
        end
      end
    end
    errors  <= mismatches;
    pending <= forest_results_q.size();
  end

endmodule

@@ sim/tb_forest_lca_link_cut.sv @@
`timescale 1ns / 100ps
// Testbench top for forest_lca_link_cut: reset, request stimulus, receiver stalls, verdict.
// Depends on fll_pkg, the block itself and fll_checker, which predicts and compares.
module tb_forest_lca_link_cut;
  import fll_pkg::*;

  localparam int NODES     = NODES_DEF;
  localparam int RUN_ITEMS = 780;
  // Worst beat: two full searches plus mark, climb and clear walks, then sender
  // gap and receiver stall; take the lot several times over.
  localparam int CYCLE_LIMIT = 3 * (RUN_ITEMS + 25) * (8 * NODES + 64);
  localparam int DRAIN_CYCLES = 64;

  localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] KEY_ONES = 32'hffff_ffff;

  typedef enum int {READY_STEADY, READY_COIN, READY_SPARSE} ready_mode_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_ready = 1'b0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;
  int   errors;
  int   pending;

  // Keys handed to inserts that found room; lookups draw from here.
  logic [KEY_W-1:0] key_pool[$];
  int               slots_used = 0;
  int               burst_left = 0;
  int               sent       = 0;

  ready_mode_t ready_mode = READY_STEADY;
  int          mode_left  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  forest_lca_link_cut #(.NODES(NODES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  fll_checker #(.NODES(NODES)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  // Receiver: hold one stall pattern for a stretch, then pick another.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      case ($urandom_range(0, 2))
        0:       ready_mode = READY_STEADY;
        1:       ready_mode = READY_COIN;
        default: ready_mode = READY_SPARSE;
      endcase
      mode_left = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      READY_STEADY: rsp_ready <= 1'b1;
      READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
      default:      rsp_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic req_t beat(input op_t op, input logic [KEY_W-1:0] a,
                                input logic [KEY_W-1:0] b);
    req_t it;
    it.op    = op;
    it.key_a = a;
    it.key_b = b;
    return it;
  endfunction

  // Mostly a known key; now and then one that is likely absent.
  function automatic logic [KEY_W-1:0] pick_key();
    if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) return $urandom();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return '0;
        default: return KEY_ONES;
      endcase
    end
    if (r == 1 && key_pool.size() != 0) return pick_key();
    return $urandom();
  endfunction

  function automatic req_t random_beat(input int insert_pct);
    req_t it;
    int   r;
    it.key_b = pick_key();
    if ($urandom_range(0, 99) < insert_pct) begin
      it.op    = OP_INSERT;
      it.key_a = fresh_key();
    end else begin
      r = $urandom_range(0, 99);
      it.op    = (r < 40) ? OP_LINK : (r < 55) ? OP_CUT : OP_LCA;
      it.key_a = pick_key();
    end
    return it;
  endfunction

  // Present one beat and hold it until taken; idle between most bursts.
  task automatic send_beat(input req_t it);
    int gap;
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (it.op == OP_INSERT && slots_used < NODES) begin
      key_pool.push_back(it.key_a);
      slots_used++;
    end
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic run_directed();
    // empty forest
    send_beat(beat(OP_LINK, 32'd1, 32'd2));
    send_beat(beat(OP_CUT, 32'd5, '0));
    send_beat(beat(OP_LCA, '0, '0));
    // extreme keys, then a duplicate
    send_beat(beat(OP_INSERT, KEY_MIN, KEY_ONES));
    send_beat(beat(OP_INSERT, KEY_MAX, '0));
    send_beat(beat(OP_INSERT, '0, KEY_MAX));
    send_beat(beat(OP_INSERT, KEY_ONES, KEY_MIN));
    send_beat(beat(OP_INSERT, 32'd5, '0));
    send_beat(beat(OP_INSERT, 32'd5, '0));
    // two children under the top key
    send_beat(beat(OP_LINK, KEY_MAX, '0));
    send_beat(beat(OP_LINK, KEY_MAX, KEY_ONES));
    send_beat(beat(OP_LCA, '0, KEY_ONES));
    send_beat(beat(OP_LCA, '0, '0));
    send_beat(beat(OP_LCA, '0, KEY_MIN));
    // absent parent, absent child, absent cut key
    send_beat(beat(OP_LINK, 32'd123, '0));
    send_beat(beat(OP_LINK, KEY_MAX, 32'd124));
    send_beat(beat(OP_CUT, 32'd77, '0));
    // cut a child off, then ask again
    send_beat(beat(OP_CUT, '0, '0));
    send_beat(beat(OP_LCA, '0, KEY_ONES));
    // self link, then a two-node cycle; walks must stay bounded
    send_beat(beat(OP_LINK, 32'd5, 32'd5));
    send_beat(beat(OP_LCA, 32'd5, KEY_ONES));
    send_beat(beat(OP_LINK, KEY_ONES, KEY_MAX));
    send_beat(beat(OP_LCA, KEY_MAX, KEY_ONES));
    send_beat(beat(OP_LCA, KEY_MIN, KEY_MIN));
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    // grow and reshape trees with a steady share of inserts
    while (sent < 300) begin
      send_beat(random_beat(30));
      sent++;
    end
    // fill the table to the brim
    while (slots_used < NODES) begin
      send_beat(random_beat(85));
      sent++;
    end
    // full table: inserts bounce, links and queries work on the whole forest
    while (sent < RUN_ITEMS) begin
      send_beat(random_beat(10));
      sent++;
    end
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: give up if the run overstays its generous allowance.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
